/* design/fet_pkg.sv */
`timescale 1ns / 1ps
// fet_pkg: widths, command and status types, and elaboration-time fixed point math
// for the fisher exact test core; no dependencies
package fet_pkg;

	localparam int MAX_N_DEF = 1023;
	localparam int CNT_W     = 10;   // one table cell
	localparam int MRG_W     = 11;   // row or column sum
	localparam int TOT_W     = 12;   // sum of all four cells
	localparam int LNF_W     = 44;   // ln(k!) in Q.24, covers k up to 65535
	localparam int LS_W      = 48;   // signed log sum
	localparam int TERM_W    = 33;   // one probability term, 1.0 is 2^32
	localparam int SUM_W     = 45;   // unsaturated p-value sum
	localparam int P_W       = 32;
	localparam int ODDS_W    = 20;
	localparam int WALK_W    = 11;
	localparam int WCNT_W    = 12;   // walked counter before truncation
	localparam int IN_W      = 40;
	localparam int OUT_W     = 152;

	// rom address source
	typedef enum logic [1:0] {
		ASEL_MARG,
		ASEL_TOTAL,
		ASEL_WALK
	} asel_t;

	typedef struct packed {
		logic  load;
		logic  setup;
		asel_t asel;
		logic  cap_sum4;
		logic  cap_marg;
		logic  cap_obs;
		logic  cap_lp;
		logic  x_to_ca;
		logic  x_to_lo;
		logic  x_inc;
		logic  exp_start;
		logic  acc;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic too_large;
		logic x_last;
		logic exp_done;
		logic out_busy;
	} sts_t;

	// floor(x * y / 2^60), truncated to 64 bits
	function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return p[123:60];
	endfunction

	// shift-subtract unsigned division
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] q;
		int i;
		rem = '0;
		q   = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// floor(num * 2^60 / den) for num < den
	function automatic logic [63:0] frac_div_q60(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] q;
		int i;
		rem = num;
		q   = '0;
		for (i = 0; i < 60; i++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q   = q | 64'd1;
			end
		end
		return q;
	endfunction

	// 2*atanh(z) in Q60 by its odd power series
	function automatic logic [63:0] two_atanh_q60(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] pw;
		logic [63:0] s;
		logic [63:0] k;
		z2 = mul_q60(z, z);
		pw = z;
		s  = '0;
		k  = 64'd1;
		while (pw != 64'd0 && k < 64'd200) begin
			s  = s + udiv64(pw, k);
			pw = mul_q60(pw, z2);
			k  = k + 64'd2;
		end
		return s << 1;
	endfunction

	localparam logic [63:0] LN2_Q60 = two_atanh_q60(frac_div_q60(64'd1, 64'd3));
	localparam logic [63:0] LN2_Q56 = LN2_Q60 >> 4;

endpackage

/* design/fet_rom.sv */
`timescale 1ns / 1ps
// fet_rom: ln(k!) table in Q.24, one registered read port
// depends on fet_pkg for the fixed point helpers
module fet_rom #(
	parameter int DEPTH = fet_pkg::MAX_N_DEF + 1
) (
	input  logic                        clk,
	input  logic [$clog2(DEPTH)-1:0]    addr,
	output logic [fet_pkg::LNF_W-1:0]   data
);

	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam logic [63:0] HALF_LSB = 64'd1 << 35;

	typedef logic [fet_pkg::LNF_W-1:0] lnf_arr_t [DEPTH];

	// running sum of ln(j): ln2 times the exponent plus 2*atanh of the mantissa ratio
	function automatic lnf_arr_t build_lnf();
		lnf_arr_t    tab;
		logic [63:0] acc_int;
		logic [63:0] acc_frac;
		logic [63:0] part;
		logic [63:0] ent;
		int unsigned e;
		int unsigned p2;
		int unsigned t;
		int unsigned j;
		acc_int  = '0;
		acc_frac = '0;
		tab[0]   = '0;
		for (j = 1; j < DEPTH; j++) begin
			e  = 0;
			p2 = 1;
			while ((p2 << 1) <= j) begin
				p2 = p2 << 1;
				e  = e + 1;
			end
			for (t = 0; t < e; t++) begin
				acc_frac = acc_frac + fet_pkg::LN2_Q60;
				if (acc_frac >= ONE_Q60) begin
					acc_frac = acc_frac - ONE_Q60;
					acc_int  = acc_int + 64'd1;
				end
			end
			if (j != p2) begin
				part = fet_pkg::two_atanh_q60(
					fet_pkg::frac_div_q60(64'(j - p2), 64'(j + p2)));
				acc_frac = acc_frac + part;
				if (acc_frac >= ONE_Q60) begin
					acc_frac = acc_frac - ONE_Q60;
					acc_int  = acc_int + 64'd1;
				end
			end
			ent    = (acc_int << 24) + ((acc_frac + HALF_LSB) >> 36);
			tab[j] = ent[fet_pkg::LNF_W-1:0];
		end
		return tab;
	endfunction

	localparam lnf_arr_t LNF = build_lnf();

	// registered read
	always_ff @(posedge clk) begin
		data <= LNF[addr];
	end

endmodule

/* design/fet_exp.sv */
`timescale 1ns / 1ps
// fet_exp: iterative exp unit, turns a Q.24 log sum into a Q1.32 term
// depends on fet_pkg; shared 32x32 multiplier and a 4-bit-per-cycle small divider
module fet_exp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [fet_pkg::LS_W-1:0]   y,
	output logic                              done,
	output logic [fet_pkg::TERM_W-1:0]        term
);

	localparam int LS_W    = fet_pkg::LS_W;
	localparam int TERM_W  = fet_pkg::TERM_W;
	localparam int RED_W   = 62;
	localparam int ACC_W   = 121;
	localparam int N_TERMS = 60;
	localparam logic [LS_W-1:0]   M_LIMIT = LS_W'(24) << 24;
	localparam logic [RED_W-1:0]  LN2_T   = RED_W'(fet_pkg::LN2_Q56);
	localparam logic [TERM_W-1:0] T_ONE   = TERM_W'(1) << 32;

	typedef enum logic [3:0] {
		E_IDLE,
		E_RED,
		E_INIT,
		E_MUL,
		E_DLD,
		E_DIV,
		E_UPD,
		E_DIFF,
		E_RND,
		E_SHF
	} est_t;

	est_t              state_q;
	logic [RED_W-1:0]  rem_q;
	logic [RED_W-1:0]  trial;
	logic [2:0]        b_q;
	logic [5:0]        k_q;
	logic [60:0]       t_q;
	logic [59:0]       r60_q;
	logic [61:0]       pos_q;
	logic [61:0]       neg_q;
	logic [5:0]        n_q;
	logic [1:0]        j_q;
	logic              ph_q;
	logic [63:0]       pp_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  pp_sh;
	logic [63:0]       dv_q;
	logic [63:0]       quo_q;
	logic [5:0]        rr_q;
	logic [3:0]        dstep_q;
	logic [61:0]       dif_q;
	logic [62:0]       rnd_q;
	logic [62:0]       shifted;
	logic [6:0]        s_amt;
	logic [LS_W-1:0]   mag;
	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [6:0]        div_r;
	logic [63:0]       div_dv;
	logic [3:0]        div_q4;
	logic [60:0]       q_new;

	assign mag   = '0 - $unsigned(y);
	assign trial = LN2_T << b_q;
	assign s_amt = 7'd28 + 7'(k_q);
	assign shifted = rnd_q >> s_amt;
	assign q_new = quo_q[60:0];

	// partial product operand select
	always_comb begin
		case (j_q)
			2'd0: begin
				op_a = t_q[31:0];
				op_b = r60_q[31:0];
			end
			2'd1: begin
				op_a = t_q[31:0];
				op_b = {4'd0, r60_q[59:32]};
			end
			2'd2: begin
				op_a = {3'd0, t_q[60:32]};
				op_b = r60_q[31:0];
			end
			default: begin
				op_a = {3'd0, t_q[60:32]};
				op_b = {4'd0, r60_q[59:32]};
			end
		endcase
	end

	// partial product weight
	always_comb begin
		case (j_q)
			2'd0:    pp_sh = ACC_W'(pp_q);
			2'd3:    pp_sh = ACC_W'(pp_q) << 64;
			default: pp_sh = ACC_W'(pp_q) << 32;
		endcase
	end

	// four quotient bits of the division by the series index
	always_comb begin
		div_r  = {1'b0, rr_q};
		div_dv = dv_q;
		div_q4 = '0;
		for (int i = 0; i < 4; i++) begin
			div_r  = {div_r[5:0], div_dv[63]};
			div_dv = div_dv << 1;
			div_q4 = {div_q4[2:0], 1'b0};
			if (div_r >= {1'b0, n_q}) begin
				div_r     = div_r - {1'b0, n_q};
				div_q4[0] = 1'b1;
			end
		end
	end

	// sequencer: early 1.0 or 0 result, else range reduction, taylor series of exp(-r), final round and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (start) begin
						if (!y[LS_W-1]) begin
							term <= T_ONE;
							done <= 1'b1;
						end else if (mag >= M_LIMIT) begin
							term <= '0;
							done <= 1'b1;
						end else begin
							rem_q   <= RED_W'({mag[28:0], 32'd0});
							k_q     <= '0;
							b_q     <= 3'd5;
							state_q <= E_RED;
						end
					end
				end
				E_RED: begin
					if (rem_q >= trial) begin
						rem_q    <= rem_q - trial;
						k_q[b_q] <= 1'b1;
					end
					if (b_q == 3'd0) begin
						state_q <= E_INIT;
					end else begin
						b_q <= b_q - 3'd1;
					end
				end
				E_INIT: begin
					r60_q   <= {rem_q[55:0], 4'd0};
					t_q     <= 61'd1 << 60;
					pos_q   <= 62'd1 << 60;
					neg_q   <= '0;
					n_q     <= 6'd1;
					j_q     <= '0;
					ph_q    <= 1'b0;
					acc_q   <= '0;
					state_q <= E_MUL;
				end
				E_MUL: begin
					if (!ph_q) begin
						pp_q <= {32'd0, op_a} * {32'd0, op_b};
						ph_q <= 1'b1;
					end else begin
						acc_q <= acc_q + pp_sh;
						ph_q  <= 1'b0;
						j_q   <= j_q + 2'd1;
						if (j_q == 2'd3) begin
							state_q <= E_DLD;
						end
					end
				end
				E_DLD: begin
					dv_q    <= {3'd0, acc_q[120:60]};
					rr_q    <= '0;
					dstep_q <= '0;
					state_q <= E_DIV;
				end
				E_DIV: begin
					dv_q    <= div_dv;
					rr_q    <= div_r[5:0];
					quo_q   <= {quo_q[59:0], div_q4};
					dstep_q <= dstep_q + 4'd1;
					if (dstep_q == 4'd15) begin
						state_q <= E_UPD;
					end
				end
				E_UPD: begin
					t_q <= q_new;
					if (n_q[0]) begin
						neg_q <= neg_q + 62'(q_new);
					end else begin
						pos_q <= pos_q + 62'(q_new);
					end
					n_q   <= n_q + 6'd1;
					j_q   <= '0;
					ph_q  <= 1'b0;
					acc_q <= '0;
					if (n_q < 6'(N_TERMS - 1) && q_new != '0) begin
						state_q <= E_MUL;
					end else begin
						state_q <= E_DIFF;
					end
				end
				E_DIFF: begin
					dif_q   <= pos_q - neg_q;
					state_q <= E_RND;
				end
				E_RND: begin
					rnd_q   <= {1'b0, dif_q} + (63'd1 << (s_amt - 7'd1));
					state_q <= E_SHF;
				end
				E_SHF: begin
					term    <= shifted[TERM_W-1:0];
					done    <= 1'b1;
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == E_IDLE)
		else $error("exp unit started while busy");

	a_nonneg_one: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !y[LS_W-1]) |=> (done && term == T_ONE))
		else $error("non-negative log sum did not give 1.0");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == E_IDLE)
		else $error("exp done while still iterating");

endmodule

/* design/fet_dpath.sv */
`timescale 1ns / 1ps
// fet_dpath: table registers, ln(k!) roms, log sums, tail sums and result register
// depends on fet_pkg, fet_rom and fet_exp
module fet_dpath #(
	parameter int MAX_N = fet_pkg::MAX_N_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fet_pkg::IN_W-1:0]      s_tdata,
	input  fet_pkg::cmd_t                 cmd,
	output fet_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fet_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tuser
);

	localparam int DEPTH  = MAX_N + 1;
	localparam int AW     = $clog2(DEPTH);
	localparam int CNT_W  = fet_pkg::CNT_W;
	localparam int MRG_W  = fet_pkg::MRG_W;
	localparam int TOT_W  = fet_pkg::TOT_W;
	localparam int LNF_W  = fet_pkg::LNF_W;
	localparam int LS_W   = fet_pkg::LS_W;
	localparam int SUM_W  = fet_pkg::SUM_W;
	localparam int P_W    = fet_pkg::P_W;
	localparam int ODDS_W = fet_pkg::ODDS_W;
	localparam int WCNT_W = fet_pkg::WCNT_W;
	localparam int WALK_W = fet_pkg::WALK_W;
	localparam int OUT_W  = fet_pkg::OUT_W;
	localparam int CMP_W  = 17;
	localparam logic [CMP_W-1:0] MAXN_V = CMP_W'(MAX_N);

	logic [CNT_W-1:0]  ca_q, cb_q, cc_q, cd_q;
	logic [TOT_W-1:0]  total;
	logic [MRG_W-1:0]  r1, r2, c1, c2;
	logic [MRG_W-1:0]  r1_q, r2_q, c1_q, c2_q;
	logic [TOT_W-1:0]  n_q;
	logic [MRG_W-1:0]  lo_q, hi_q, x_q;
	logic [MRG_W-1:0]  tb, tc;
	logic [TOT_W-1:0]  td;
	logic [ODDS_W-1:0] prod_ad, prod_bc, num_q, den_q;
	logic              too_q;
	logic [AW-1:0]     addr [4];
	logic [LNF_W-1:0]  rd [4];
	logic signed [LS_W-1:0] sum4, sum4_q, marg_q, obs_q, lp_q;
	logic [fet_pkg::TERM_W-1:0] term;
	logic              exp_done;
	logic [SUM_W-1:0]  sl_q, sr_q, st_q;
	logic [WCNT_W-1:0] walked_q;
	logic [P_W-1:0]    pl, pr, pt;
	logic              mvalid_q;

	// margins of the latched table
	assign total = TOT_W'(ca_q) + TOT_W'(cb_q) + TOT_W'(cc_q) + TOT_W'(cd_q);
	assign r1 = MRG_W'(ca_q) + MRG_W'(cb_q);
	assign r2 = MRG_W'(cc_q) + MRG_W'(cd_q);
	assign c1 = MRG_W'(ca_q) + MRG_W'(cc_q);
	assign c2 = MRG_W'(cb_q) + MRG_W'(cd_q);
	assign prod_ad = ODDS_W'(ca_q) * ODDS_W'(cd_q);
	assign prod_bc = ODDS_W'(cb_q) * ODDS_W'(cc_q);

	// cells of the walked table
	assign tb = r1_q - x_q;
	assign tc = c1_q - x_q;
	assign td = TOT_W'(r2_q) + TOT_W'(x_q) - TOT_W'(c1_q);

	// rom address select
	always_comb begin
		case (cmd.asel)
			fet_pkg::ASEL_MARG: begin
				addr[0] = AW'(r1_q);
				addr[1] = AW'(r2_q);
				addr[2] = AW'(c1_q);
				addr[3] = AW'(c2_q);
			end
			fet_pkg::ASEL_TOTAL: begin
				addr[0] = AW'(n_q);
				addr[1] = AW'(n_q);
				addr[2] = AW'(n_q);
				addr[3] = AW'(n_q);
			end
			default: begin
				addr[0] = AW'(x_q);
				addr[1] = AW'(tb);
				addr[2] = AW'(tc);
				addr[3] = AW'(td);
			end
		endcase
	end

	for (genvar g = 0; g < 4; g++) begin : g_rom
		fet_rom #(
			.DEPTH(DEPTH)
		) u_rom (
			.clk (clk),
			.addr(addr[g]),
			.data(rd[g])
		);
	end

	assign sum4 = $signed(LS_W'(rd[0]) + LS_W'(rd[1]) + LS_W'(rd[2]) + LS_W'(rd[3]));

	fet_exp u_exp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.exp_start),
		.y     (lp_q),
		.done  (exp_done),
		.term  (term)
	);

	// table, margins, odds, walk index and log sums
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ca_q <= s_tdata[CNT_W-1:0];
			cb_q <= s_tdata[2*CNT_W-1:CNT_W];
			cc_q <= s_tdata[3*CNT_W-1:2*CNT_W];
			cd_q <= s_tdata[4*CNT_W-1:3*CNT_W];
		end
		if (cmd.setup) begin
			r1_q  <= r1;
			r2_q  <= r2;
			c1_q  <= c1;
			c2_q  <= c2;
			n_q   <= total;
			lo_q  <= (r1 > c2) ? r1 - c2 : '0;
			hi_q  <= (r1 < c1) ? r1 : c1;
			num_q <= (prod_ad == '0) ? ODDS_W'(1) : {prod_ad[ODDS_W-2:0], 1'b0};
			den_q <= (prod_bc == '0) ? ODDS_W'(1) : {prod_bc[ODDS_W-2:0], 1'b0};
			too_q <= CMP_W'(total) > MAXN_V;
		end
		if (cmd.cap_sum4) begin
			sum4_q <= sum4;
		end
		if (cmd.cap_marg) begin
			marg_q <= sum4_q - $signed(LS_W'(rd[0]));
		end
		if (cmd.cap_obs) begin
			obs_q <= marg_q - sum4_q;
		end
		if (cmd.cap_lp) begin
			lp_q <= marg_q - sum4_q;
		end
		if (cmd.x_to_ca) begin
			x_q <= MRG_W'(ca_q);
		end else if (cmd.x_to_lo) begin
			x_q <= lo_q;
		end else if (cmd.x_inc) begin
			x_q <= x_q + MRG_W'(1);
		end
	end

	// tail sums and walked count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sl_q     <= '0;
			sr_q     <= '0;
			st_q     <= '0;
			walked_q <= '0;
		end else if (cmd.setup) begin
			sl_q     <= '0;
			sr_q     <= '0;
			st_q     <= '0;
			walked_q <= '0;
		end else if (cmd.acc) begin
			if (x_q <= MRG_W'(ca_q)) begin
				sl_q <= sl_q + SUM_W'(term);
			end
			if (x_q >= MRG_W'(ca_q)) begin
				sr_q <= sr_q + SUM_W'(term);
			end
			if (lp_q <= obs_q) begin
				st_q <= st_q + SUM_W'(term);
			end
			walked_q <= walked_q + WCNT_W'(1);
		end
	end

	// saturate to all ones, just below 1.0
	assign pl = (|sl_q[SUM_W-1:P_W]) ? '1 : sl_q[P_W-1:0];
	assign pr = (|sr_q[SUM_W-1:P_W]) ? '1 : sr_q[P_W-1:0];
	assign pt = (|st_q[SUM_W-1:P_W]) ? '1 : st_q[P_W-1:0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (too_q) begin
				m_tdata <= '0;
				m_tuser <= 1'b1;
			end else begin
				m_tdata <= OUT_W'({walked_q[WALK_W-1:0], den_q, num_q, pt, pr, pl});
				m_tuser <= 1'b0;
			end
		end
	end

	assign m_tvalid      = mvalid_q;
	assign sts.too_large = CMP_W'(total) > MAXN_V;
	assign sts.x_last    = x_q == hi_q;
	assign sts.exp_done  = exp_done;
	assign sts.out_busy  = mvalid_q && !m_tready;

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> (x_q >= lo_q && x_q <= hi_q))
		else $error("walked table outside margin range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(mvalid_q && !m_tready))
		else $error("result word overwritten before taken");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> walked_q <= WCNT_W'(hi_q - lo_q))
		else $error("walked count ahead of table index");

endmodule

/* design/fet_ctrl.sv */
`timescale 1ns / 1ps
// fet_ctrl: sequencer for setup, observed log sum and the table walk
// depends on fet_pkg for the command and status types
module fet_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output fet_pkg::cmd_t  cmd,
	input  fet_pkg::sts_t  sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_MRD1,
		S_MRD2,
		S_MCAP,
		S_OLOOK,
		S_OADD,
		S_ODIFF,
		S_LOOK,
		S_ADD,
		S_DIFF,
		S_EXP,
		S_EXPW,
		S_FIN
	} st_t;

	st_t state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (s_tvalid) state_q <= S_CHK;
				S_CHK:   state_q <= sts.too_large ? S_FIN : S_MRD1;
				S_MRD1:  state_q <= S_MRD2;
				S_MRD2:  state_q <= S_MCAP;
				S_MCAP:  state_q <= S_OLOOK;
				S_OLOOK: state_q <= S_OADD;
				S_OADD:  state_q <= S_ODIFF;
				S_ODIFF: state_q <= S_LOOK;
				S_LOOK:  state_q <= S_ADD;
				S_ADD:   state_q <= S_DIFF;
				S_DIFF:  state_q <= S_EXP;
				S_EXP:   state_q <= S_EXPW;
				S_EXPW: begin
					if (sts.exp_done) begin
						state_q <= sts.x_last ? S_FIN : S_LOOK;
					end
				end
				S_FIN:   if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd      = '0;
		cmd.asel = fet_pkg::ASEL_WALK;
		case (state_q)
			S_IDLE:  cmd.load = s_tvalid;
			S_CHK:   cmd.setup = 1'b1;
			S_MRD1:  cmd.asel = fet_pkg::ASEL_MARG;
			S_MRD2: begin
				cmd.asel     = fet_pkg::ASEL_TOTAL;
				cmd.cap_sum4 = 1'b1;
			end
			S_MCAP: begin
				cmd.cap_marg = 1'b1;
				cmd.x_to_ca  = 1'b1;
			end
			S_OADD:  cmd.cap_sum4 = 1'b1;
			S_ODIFF: begin
				cmd.cap_obs = 1'b1;
				cmd.x_to_lo = 1'b1;
			end
			S_ADD:   cmd.cap_sum4 = 1'b1;
			S_DIFF:  cmd.cap_lp = 1'b1;
			S_EXP:   cmd.exp_start = 1'b1;
			S_EXPW: begin
				cmd.acc   = sts.exp_done;
				cmd.x_inc = sts.exp_done && !sts.x_last;
			end
			S_FIN:   cmd.out_load = !sts.out_busy;
			default: cmd.asel = fet_pkg::ASEL_WALK;
		endcase
	end

	assign s_tready = state_q == S_IDLE;

endmodule

/* design/fisher_exact_test_2x2_core.sv */
`timescale 1ns / 1ps
// a too-large total goes straight to the result. Otherwise each table of the walk starts the exp
// unit, which gives 1.0 or 0 at once when the log sum is non-negative or at or below -24, else runs
// series steps, each a product on the shared 32x32 multiplier, a divider load, a division on the
// 4-bit-per-cycle divider and an update. one table at a time; the next word is taken once the
// result is in the output register. reset clears the sequencers, tail sums, walked count and
// output valid only; the ln(k!) roms are constant and need no clearing pass.
module fisher_exact_test_2x2_core #(
	parameter int MAX_N = fet_pkg::MAX_N_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [fet_pkg::IN_W-1:0]     s_tdata,   // count_a, count_b, count_c, count_d
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [fet_pkg::OUT_W-1:0]    m_tdata,   // p_left, p_right, p_two_sided,
	                                                // odds_numerator, odds_denominator,
	                                                // tables_walked, zero fill
	output logic                         m_tuser    // total_too_large
);

	fet_pkg::cmd_t cmd;
	fet_pkg::sts_t sts;

	fet_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	fet_dpath #(
		.MAX_N(MAX_N)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
